// ===== src/oukl_pkg.sv =====
// ============================================================================
// oukl_pkg: shared types and constants for the ordered unique key list
// Holds the list depth, the derived index widths, the request and status
// codes, the sequencer states and the request and response transaction types.
// ============================================================================
package oukl_pkg;

    // Capacity of the list and the widths that follow from it.
    localparam int LIST_DEPTH = 16;
    localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    // Fixed field widths of the transactions.
    localparam int KEY_W    = 32;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 3;

    // Request codes.
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR
    } state_t;

    // Request transaction.
    typedef struct packed {
        logic [1:0]              req_type;
        logic signed [KEY_W-1:0] key;
    } request_t;

    // Response transaction.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [POS_W-1:0]    position;
        logic [COUNT_W-1:0]  entry_count;
    } response_t;

endpackage

// ===== src/ordered_unique_key_list_core.sv =====
// ============================================================================
// ordered_unique_key_list_core: bounded list of distinct keys in insert order
// A small sequencer drives one key memory and one equality comparator. It
// scans the held entries for the key, then appends, reports, or closes the
// gap left by a removed key by moving the later entries down one place.
// ============================================================================
//
//  Channel    Signals                  Handshake
//  ---------  -----------------------  ------------------------------------
//  request    start, busy, request     taken when start is high, busy low
//  response   done, response           valid for the single cycle done is high
//
//  Steps: each entry scanned is a memory read, then a compare, and the decision
//  follows; an insert or lookup examines at most LIST_DEPTH entries. A remove
//  then moves each later entry down, a read and a write per entry, before the
//  response. Reset clears the count and the sequencer but not the key memory,
//  as only entries below the count are read. The receiver cannot stall: done
//  pulses once, with busy already low.
// ============================================================================
module ordered_unique_key_list_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  oukl_pkg::request_t  request,
    output logic                busy,
    output logic                done,
    output oukl_pkg::response_t response
);
    import oukl_pkg::*;

    // Key memory and its registered read data.
    logic [KEY_W-1:0]  key_mem [LIST_DEPTH];
    logic [KEY_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [KEY_W-1:0]  mem_wdata;

    // Sequencer state.
    state_t            state_reg, state_next;
    logic [1:0]        op_reg, op_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  idx_inc;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic              hit_reg, hit_next;
    logic              done_reg, done_next;
    response_t         rsp_reg, rsp_next;

    assign idx_inc = idx_reg + CNT_W'(1);

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= key_mem[rd_addr];
    end

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        key_reg <= key_next;
        idx_reg <= idx_next;
        hit_reg <= hit_next;
        rsp_reg <= rsp_next;
    end

    // Next state, memory control and response.
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        idx_next   = idx_reg;
        occ_next   = occ_reg;
        hit_next   = hit_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        rd_addr    = idx_reg[ADDR_W-1:0];
        mem_we     = 1'b0;
        mem_waddr  = occ_reg[ADDR_W-1:0];
        mem_wdata  = key_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = request.req_type;
                    key_next = request.key;
                    idx_next = '0;
                    hit_next = 1'b0;
                    // Nothing to scan in an empty list or for the unused code.
                    if (occ_reg == '0 || request.req_type > REQ_LOOKUP)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end

            S_SCAN_RD:
            begin
                rd_addr    = idx_reg[ADDR_W-1:0];
                state_next = S_SCAN_CMP;
            end

            S_SCAN_CMP:
            begin
                // One entry compared per pass; stop on a match or at the tail.
                if (rd_data_reg == key_reg)
                begin
                    hit_next   = 1'b1;
                    state_next = S_DECIDE;
                end
                else if (idx_inc >= occ_reg)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_SCAN_RD;
                end
            end

            S_DECIDE:
            begin
                rsp_next.status   = ST_OK;
                rsp_next.found    = 1'b0;
                rsp_next.position = '0;
                state_next        = S_IDLE;
                done_next         = 1'b1;
                case (op_reg)
                    REQ_INSERT:
                    begin
                        if (hit_reg)
                        begin
                            rsp_next.status   = ST_DUP;
                            rsp_next.found    = 1'b1;
                            rsp_next.position = POS_W'(idx_reg);
                        end
                        else if (occ_reg == CNT_W'(LIST_DEPTH))
                        begin
                            rsp_next.status = ST_FULL;
                        end
                        else
                        begin
                            mem_we            = 1'b1;
                            mem_waddr         = occ_reg[ADDR_W-1:0];
                            rsp_next.position = POS_W'(occ_reg);
                            occ_next          = occ_reg + CNT_W'(1);
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (occ_reg == '0)
                        begin
                            rsp_next.status = ST_EMPTY;
                        end
                        else if (hit_reg)
                        begin
                            // Close the gap before the response goes out.
                            rsp_next.found    = 1'b1;
                            rsp_next.position = POS_W'(idx_reg);
                            done_next         = 1'b0;
                            state_next        = S_SHIFT_RD;
                        end
                        else
                        begin
                            rsp_next.status = ST_NOT_FOUND;
                        end
                    end
                    REQ_LOOKUP:
                    begin
                        if (hit_reg)
                        begin
                            rsp_next.found    = 1'b1;
                            rsp_next.position = POS_W'(idx_reg);
                        end
                        else
                        begin
                            rsp_next.status = ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        // Unused request code: acknowledged and ignored.
                    end
                endcase
                rsp_next.entry_count = COUNT_W'(occ_next);
            end

            S_SHIFT_RD:
            begin
                // Fetch the next later entry, or finish at the tail.
                if (idx_inc < occ_reg)
                begin
                    rd_addr    = idx_inc[ADDR_W-1:0];
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    occ_next             = occ_reg - CNT_W'(1);
                    rsp_next.entry_count = COUNT_W'(occ_next);
                    done_next            = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            S_SHIFT_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[ADDR_W-1:0];
                mem_wdata  = rd_data_reg;
                idx_next   = idx_inc;
                state_next = S_SHIFT_RD;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign response = rsp_reg;

    // The response appears only once the sequencer is back at rest.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("response issued while the sequencer is busy");

    // The entry count never exceeds the capacity.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(LIST_DEPTH))
        else $error("entry count exceeds list capacity");

    // An accepted transaction always makes the block busy.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not start the sequencer");

    // A response follows only a decision or the end of a gap closure.
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == S_DECIDE || $past(state_reg) == S_SHIFT_RD))
        else $error("response issued from an unexpected state");

    // The count changes only in a response cycle.
    a_occ_change: assert property (@(posedge clk) disable iff (!rst_n)
        !done |=> $stable(occ_reg) || done)
        else $error("entry count changed without a response");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for ordered_unique_key_list_core
// Drives insert, remove, lookup and unused requests into the list core. Each
// accepted transaction is run through a local copy of the list to work out
// its response. Every response strobe is checked against the oldest expected
// response. A short directed sequence covers the empty list, extreme keys,
// duplicates, gap closing and unused requests. Random phases then fill the
// list to capacity, mix traffic, drain it to empty and run back to back.
// ============================================================================
module testbench;

    import oukl_pkg::*;

    // Request code that the block ignores.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Extreme and notable keys.
    localparam logic signed [KEY_W-1:0] KEY_MIN  = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [KEY_W-1:0] KEY_ZERO = 32'sd0;
    localparam logic signed [KEY_W-1:0] KEY_NEG1 = -32'sd1;

    // Random keys come mostly from a pool larger than the list.
    localparam int POOL_SIZE = 24;

    // Cycles to wait after the last response for any stray strobe.
    localparam int SETTLE_CYCLES = 4 * LIST_DEPTH + 16;

    localparam int MAX_REPORTS = 10;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    request_t  request = '0;
    logic      busy;
    logic      done;
    response_t response;

    // Local copy of the list contents, head at index 0.
    logic signed [KEY_W-1:0] list_keys [LIST_DEPTH];
    int                      list_count = 0;

    // Responses predicted for accepted transactions, oldest first.
    response_t pending_list_results [$];

    logic signed [KEY_W-1:0] key_pool [POOL_SIZE];

    int error_count    = 0;
    int checked_count  = 0;
    int op_tally [4]     = '{default: 0};
    int status_tally [8] = '{default: 0};

    ordered_unique_key_list_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .request  (request),
        .busy     (busy),
        .done     (done),
        .response (response)
    );

    // Free-running clock, 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Work out the response to one request and update the local list.
    function automatic response_t predict_list_op(input request_t req);
        response_t rsp;
        int        idx;
        rsp = '0;
        idx = list_count;
        for (int i = 0; i < list_count; i++)
        begin
            if (list_keys[i] == req.key && idx == list_count)
                idx = i;
        end
        case (req.req_type)
            REQ_INSERT:
            begin
                if (idx < list_count)
                begin
                    rsp.status   = ST_DUP;
                    rsp.found    = 1'b1;
                    rsp.position = idx[POS_W-1:0];
                end
                else if (list_count >= LIST_DEPTH)
                begin
                    rsp.status = ST_FULL;
                end
                else
                begin
                    list_keys[list_count] = req.key;
                    rsp.status   = ST_OK;
                    rsp.position = list_count[POS_W-1:0];
                    list_count++;
                end
            end
            REQ_REMOVE:
            begin
                if (list_count == 0)
                begin
                    rsp.status = ST_EMPTY;
                end
                else if (idx < list_count)
                begin
                    rsp.status   = ST_OK;
                    rsp.found    = 1'b1;
                    rsp.position = idx[POS_W-1:0];
                    // Close the gap so the insertion order is kept.
                    for (int i = idx; i + 1 < list_count; i++)
                        list_keys[i] = list_keys[i + 1];
                    list_count--;
                end
                else
                begin
                    rsp.status = ST_NOT_FOUND;
                end
            end
            REQ_LOOKUP:
            begin
                if (idx < list_count)
                begin
                    rsp.status   = ST_OK;
                    rsp.found    = 1'b1;
                    rsp.position = idx[POS_W-1:0];
                end
                else
                begin
                    rsp.status = ST_NOT_FOUND;
                end
            end
            default:
            begin
                rsp.status = ST_OK;
            end
        endcase
        rsp.entry_count = list_count[COUNT_W-1:0];
        return rsp;
    endfunction

    // Idle gap: mostly none or short, now and then long.
    function automatic int random_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(3, 1);
        else if (r < 97)
            return $urandom_range(12, 4);
        else
            return $urandom_range(80, 20);
    endfunction

    // Keys: mostly from the pool so hits and duplicates are common, some
    // one bit away from a pool key, and some fully random.
    function automatic logic signed [KEY_W-1:0] pick_key();
        int          r;
        logic [31:0] k;
        r = $urandom_range(99);
        if (r < 80)
            return key_pool[$urandom_range(POOL_SIZE - 1)];
        k = key_pool[$urandom_range(POOL_SIZE - 1)];
        if (r < 92)
            return k ^ (32'd1 << $urandom_range(31));
        return $urandom;
    endfunction

    // Present one transaction, wait until it is taken, record its response
    // and then idle for the requested number of cycles.
    task automatic send_request(input logic [1:0] op, input logic signed [KEY_W-1:0] k,
                                input int gap);
        request_t  req;
        response_t rsp;
        req.req_type = op;
        req.key      = k;
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        rsp = predict_list_op(req);
        pending_list_results.push_back(rsp);
        op_tally[op]++;
        status_tally[rsp.status]++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold the sender back until every predicted response has arrived.
    task automatic wait_for_responses();
        start <= 1'b0;
        while (pending_list_results.size() != 0)
            @(posedge clk);
    endtask

    // Random traffic with the given mix; unused requests do not count.
    task automatic run_random_phase(input int n_items, input int insert_pct,
                                    input int remove_pct, input bit no_idle);
        int         sent;
        int         r;
        logic [1:0] op;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(99);
            if (r < 2)
                op = REQ_UNUSED;
            else if (r < 2 + insert_pct)
                op = REQ_INSERT;
            else if (r < 2 + insert_pct + remove_pct)
                op = REQ_REMOVE;
            else
                op = REQ_LOOKUP;
            send_request(op, pick_key(), no_idle ? 0 : random_gap());
            if (op != REQ_UNUSED)
                sent++;
        end
    endtask

    // Removal and lookup on a list that holds nothing.
    task automatic test_empty_list();
        send_request(REQ_LOOKUP, KEY_MAX, random_gap());
        send_request(REQ_REMOVE, KEY_MIN, random_gap());
    endtask

    // Inserts of the extreme keys, a duplicate, and lookups at head, tail,
    // one bit away from a held key and of an absent key.
    task automatic test_insert_and_search();
        send_request(REQ_INSERT, KEY_MIN, random_gap());
        send_request(REQ_INSERT, KEY_MAX, random_gap());
        send_request(REQ_INSERT, KEY_ZERO, random_gap());
        send_request(REQ_INSERT, KEY_NEG1, random_gap());
        send_request(REQ_INSERT, KEY_ZERO, random_gap());
        send_request(REQ_LOOKUP, KEY_MIN, random_gap());
        send_request(REQ_LOOKUP, KEY_NEG1, random_gap());
        send_request(REQ_LOOKUP, 32'sd1, random_gap());
        send_request(REQ_LOOKUP, 32'sh7FFF_FFFE, random_gap());
    endtask

    // Removal from the middle, tail and head, with lookups showing that the
    // later keys have moved down, and removal of an absent key.
    task automatic test_remove_order();
        send_request(REQ_REMOVE, KEY_MAX, random_gap());
        send_request(REQ_LOOKUP, KEY_ZERO, random_gap());
        send_request(REQ_REMOVE, KEY_NEG1, random_gap());
        send_request(REQ_REMOVE, 32'sd12345, random_gap());
        send_request(REQ_REMOVE, KEY_MIN, random_gap());
        send_request(REQ_LOOKUP, KEY_ZERO, random_gap());
    endtask

    // The unused request code, then the list emptied and removed from again.
    task automatic test_unused_request();
        send_request(REQ_UNUSED, KEY_NEG1, random_gap());
        send_request(REQ_REMOVE, KEY_ZERO, random_gap());
        send_request(REQ_REMOVE, KEY_ZERO, random_gap());
    endtask

    // Insert-heavy traffic so that the list reaches capacity often.
    task automatic test_fill_to_capacity();
        run_random_phase(200, 70, 10, 1'b0);
    endtask

    // Balanced traffic around a partly filled list.
    task automatic test_mixed_traffic(input int n_items);
        run_random_phase(n_items, 35, 30, 1'b0);
    endtask

    // Remove-heavy traffic so that the list empties often.
    task automatic test_drain_to_empty();
        run_random_phase(200, 20, 60, 1'b0);
    endtask

    // Transactions offered on every cycle with no idling.
    task automatic test_back_to_back();
        run_random_phase(150, 40, 30, 1'b1);
    endtask

    // Check each response strobe against the oldest expected response.
    always @(posedge clk)
    begin
        response_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_list_results.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: response with none expected: status %0d found %0d pos %0d count %0d",
                             $realtime, response.status, response.found,
                             response.position, response.entry_count);
            end
            else
            begin
                want = pending_list_results.pop_front();
                checked_count++;
                if (response.status !== want.status || response.found !== want.found ||
                    response.position !== want.position ||
                    response.entry_count !== want.entry_count)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: mismatch: expected status %0d found %0d pos %0d count %0d, got status %0d found %0d pos %0d count %0d",
                                 $realtime, want.status, want.found, want.position,
                                 want.entry_count, response.status, response.found,
                                 response.position, response.entry_count);
                end
            end
        end
    end

    // Test sequence.
    initial
    begin
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = KEY_ZERO;
        key_pool[3] = KEY_NEG1;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_insert_and_search();
        test_remove_order();
        test_unused_request();
        wait_for_responses();

        test_fill_to_capacity();
        test_mixed_traffic(350);
        wait_for_responses();
        test_drain_to_empty();
        test_back_to_back();
        wait_for_responses();
        test_mixed_traffic(150);

        wait_for_responses();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (pending_list_results.size() != 0)
        begin
            error_count++;
            $display("%0d expected responses never arrived", pending_list_results.size());
        end

        $display("Requests: insert %0d, remove %0d, lookup %0d, unused %0d; %0d responses checked",
                 op_tally[REQ_INSERT], op_tally[REQ_REMOVE], op_tally[REQ_LOOKUP],
                 op_tally[REQ_UNUSED], checked_count);
        $display("Outcomes: ok %0d, duplicate %0d, not found %0d, empty %0d, full %0d; %0d errors",
                 status_tally[ST_OK], status_tally[ST_DUP], status_tally[ST_NOT_FOUND],
                 status_tally[ST_EMPTY], status_tally[ST_FULL], error_count);
        if (error_count == 0)
            $display("ordered_unique_key_list_core test passed");
        else
            $display("ordered_unique_key_list_core test failed");
        $finish;
    end

    // Watchdog: ends a run that has hung.
    initial
    begin
        #2_000_000;
        $display("ordered_unique_key_list_core test failed");
        $finish;
    end

endmodule
